// ===== rtl/rsc_pkg.sv =====
// Shared types, codes and helpers for the RPN stack calculator.
package rsc_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int VAR_COUNT_DEF   = 26;
  localparam int DATA_W          = 64;
  localparam int HALF_W          = 32;
  localparam int CMD_W           = 5;
  localparam int VIDX_W          = 5;
  localparam int IN_TDATA_W      = 80;
  localparam int OUT_TDATA_W     = 72;
  localparam int DIV_STEPS       = 64;

  typedef enum logic [4:0] {
    CMD_PUSH = 5'd0, CMD_ADD = 5'd1, CMD_SUB = 5'd2, CMD_MUL = 5'd3,
    CMD_AND = 5'd4, CMD_OR = 5'd5, CMD_XOR = 5'd6, CMD_MIN = 5'd7,
    CMD_MAX = 5'd8, CMD_DIV = 5'd9, CMD_MOD = 5'd10, CMD_STORE = 5'd11,
    CMD_FETCH = 5'd12, CMD_PRINT_B = 5'd13, CMD_PRINT_W = 5'd14,
    CMD_PRINT_L = 5'd15, CMD_PRINT_Q = 5'd16, CMD_CHAR = 5'd17
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_PRINT = 2'd0, KIND_CHAR = 2'd1, KIND_ERROR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0, ERR_UNDERRUN = 2'd1, ERR_OVERRUN = 2'd2
  } err_t;

  typedef enum logic [2:0] {
    CLS_NOP, CLS_PUSH, CLS_FETCH, CLS_STORE, CLS_PRINT, CLS_CHAR, CLS_BIN
  } cls_t;

  typedef enum logic [3:0] {
    ALU_ADD, ALU_SUB, ALU_MUL, ALU_AND, ALU_OR, ALU_XOR,
    ALU_MIN, ALU_MAX, ALU_DIV, ALU_MOD
  } alu_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DECIDE, ST_POP, ST_FETCH, ST_RDA, ST_RDB,
    ST_EXEC, ST_MUL, ST_DIV, ST_FIX, ST_WB, ST_OUT
  } bstate_t;

  typedef struct packed {
    cls_t              cls;
    alu_t              alu;
    logic [1:0]        pw;
    logic [DATA_W-1:0] val;
    logic [VIDX_W-1:0] vidx;
    logic              start;
  } token_t;

  typedef struct packed {
    logic   valid;
    kind_t  kind;
    logic [DATA_W-1:0] value;
    logic [1:0] pw;
    err_t   code;
  } result_t;

  function automatic logic [DATA_W-1:0] print_mask(input logic [1:0] w);
    logic [DATA_W-1:0] m;
    case (w)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

// ===== rtl/rpn_stack_calculator_core.sv =====
// Top level of the RPN stack calculator: input side, token queue, execute side.
//
// Usage: each input transaction carries one decoded token (command, operand,
// variable index, start-of-program flag). The core keeps a stack of
// StackDepth 64-bit words and VarCount variables. Print, char and error
// tokens give one output transaction while no sticky error is set; all others
// give none. The output tuser holds the result kind, tdata the value, print
// width and error code. Each token is popped off the two-entry queue, then
// executed. Mul forms three 32x32 partial products in one shared multiplier;
// div and mod use a restoring divider that takes one quotient bit per cycle
// and is skipped with a zero divisor.
// One token is executed at a time; the queue keeps accepting up to two more.
// Reset empties the stack, clears the variables and the sticky error, and
// drops any queued tokens. When the receiver stalls, the result holds in the
// output register; the core keeps working until its next result is ready.
module rpn_stack_calculator_core #(
  parameter int StackDepth = rsc_pkg::STACK_DEPTH_DEF,
  parameter int VarCount   = rsc_pkg::VAR_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // command[4:0], operand_value[68:5], var_index[73:69], start_program[74]
  input  logic [rsc_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // result_value[63:0], print_width[65:64], error_code[67:66]
  output logic [rsc_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // result_kind[1:0]
  output logic [1:0]                       out_tuser
);
  import rsc_pkg::*;

  logic    q_full, q_push, q_valid, q_pop;
  token_t  push_tok, head_tok;
  result_t res;
  logic [$clog2(StackDepth+1)-1:0] count;

  rsc_front u_front (
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .q_full(q_full), .q_push(q_push), .q_tok(push_tok)
  );

  rsc_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(q_push), .push_tok(push_tok),
    .full(q_full), .pop(q_pop), .head_valid(q_valid), .head_tok(head_tok)
  );

  rsc_back #(.StackDepth(StackDepth), .VarCount(VarCount)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_tok(head_tok),
    .q_pop(q_pop), .res(res), .out_ready(out_tready),
    .count(count)
  );

  assign out_tvalid = res.valid;
  assign out_tuser  = res.kind;
  assign out_tdata  = {4'd0, res.code, res.pw, res.value};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count) <= StackDepth)
    else $error("stack count beyond depth");
  a_err_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR |-> res.code != ERR_NONE && res.value == '0)
    else $error("error result without error code");
  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_full && !q_pop |=> q_full)
    else $error("queue lost an entry");
`endif
endmodule

// ===== rtl/rsc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/rsc_front.sv =====
// Input side: unpack an incoming token and classify it for the execute side.
module rsc_front (
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rsc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            q_full,
  output logic                            q_push,
  output rsc_pkg::token_t                 q_tok
);
  import rsc_pkg::*;

  logic [CMD_W-1:0] cmd;

  assign cmd       = in_tdata[4:0];
  assign in_tready = !q_full;
  assign q_push    = in_tvalid && !q_full;

  always_comb begin
    q_tok       = '0;
    q_tok.val   = in_tdata[68:5];
    q_tok.vidx  = in_tdata[73:69];
    q_tok.start = in_tdata[74];
    q_tok.pw    = 2'(cmd - CMD_PRINT_B);
    q_tok.alu   = ALU_ADD;
    case (cmd) inside
      CMD_PUSH:                  q_tok.cls = CLS_PUSH;
      CMD_FETCH:                 q_tok.cls = CLS_FETCH;
      CMD_STORE:                 q_tok.cls = CLS_STORE;
      [CMD_PRINT_B:CMD_PRINT_Q]: q_tok.cls = CLS_PRINT;
      CMD_CHAR:                  q_tok.cls = CLS_CHAR;
      [CMD_ADD:CMD_MOD]: begin
        q_tok.cls = CLS_BIN;
        q_tok.alu = alu_t'(4'(cmd - CMD_ADD));
      end
      default:                   q_tok.cls = CLS_NOP;
    endcase
  end
endmodule

// ===== rtl/rsc_fifo.sv =====
// Two-entry token queue between the input side and the execute side.
module rsc_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  rsc_pkg::token_t push_tok,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output rsc_pkg::token_t head_tok
);
  import rsc_pkg::*;

  token_t     mem_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;

  assign full       = cnt_r == 2'd2;
  assign head_valid = cnt_r != 2'd0;
  assign head_tok   = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wptr_r] <= push_tok;
    end
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= !wptr_r;
      if (pop)  rptr_r <= !rptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== rtl/rsc_back.sv =====
// Execute side: stack and variable memories, ALU, multiplier and divider.
module rsc_back #(
  parameter int StackDepth = rsc_pkg::STACK_DEPTH_DEF,
  parameter int VarCount   = rsc_pkg::VAR_COUNT_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  rsc_pkg::token_t                    q_tok,
  output logic                               q_pop,
  output rsc_pkg::result_t                   res,
  input  logic                               out_ready,
  output logic [$clog2(StackDepth+1)-1:0]    count
);
  import rsc_pkg::*;

  localparam int CW  = $clog2(StackDepth + 1);
  localparam int AW  = $clog2(StackDepth);
  localparam int VAW = VarCount > 1 ? $clog2(VarCount) : 1;
  localparam int XW  = VAW > VIDX_W ? VAW : VIDX_W;

  bstate_t state_r, state_nxt;
  token_t  tok_r, tok_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          err_r, err_nxt;
  logic [VarCount-1:0] vvld_r, vvld_nxt;
  logic          vsel_r, vsel_nxt;
  logic [DATA_W-1:0] a_r, a_nxt, b_r, b_nxt, r_r, r_nxt, rem_r, rem_nxt;
  logic [5:0]    step_r, step_nxt;
  logic          na_r, na_nxt, nb_r, nb_nxt;
  result_t       pend_r, pend_nxt, res_r, res_nxt;

  logic              s_we, v_we;
  logic [AW-1:0]     s_waddr, s_raddr;
  logic [DATA_W-1:0] s_wdata, s_rdata, v_wdata, v_rdata;
  logic [VAW-1:0]    vaddr;
  logic [XW-1:0]     vx;
  logic [CW-1:0]     cm1, cm2;
  logic              stk_full, has1, has2, vin, res_free;
  logic [HALF_W-1:0] mx, my;
  logic [DATA_W-1:0] prod;
  logic [DATA_W:0]   rem_sh, diff;

  rsc_ram #(.WIDTH(DATA_W), .DEPTH(StackDepth)) u_stack (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  rsc_ram #(.WIDTH(DATA_W), .DEPTH(VarCount)) u_vars (
    .clk(clk), .we(v_we), .waddr(vaddr), .wdata(v_wdata),
    .raddr(vaddr), .rdata(v_rdata)
  );

  assign cm1      = count_r - CW'(1);
  assign cm2      = count_r - CW'(2);
  assign stk_full = count_r == CW'(StackDepth);
  assign has1     = count_r != '0;
  assign has2     = count_r >= CW'(2);
  assign vx       = XW'(tok_r.vidx);
  assign vaddr    = vx[VAW-1:0];
  assign vin      = 32'(tok_r.vidx) < VarCount;
  assign res_free = !res_r.valid || out_ready;
  assign res      = res_r;
  assign count    = count_r;
  assign q_pop    = state_r == ST_IDLE && q_valid;

  always_comb begin
    case (step_r[1:0])
      2'd0:    begin mx = a_r[31:0];  my = b_r[31:0];  end
      2'd1:    begin mx = a_r[31:0];  my = b_r[63:32]; end
      default: begin mx = a_r[63:32]; my = b_r[31:0];  end
    endcase
    prod   = DATA_W'(mx * my);
    rem_sh = {rem_r, r_r[DATA_W-1]};
    diff   = rem_sh - {1'b0, a_r};
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (q_valid) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (err_r) begin
          state_nxt = ST_IDLE;
        end else begin
          case (tok_r.cls)
            CLS_CHAR:  state_nxt = ST_OUT;
            CLS_PUSH:  state_nxt = stk_full ? ST_OUT : ST_IDLE;
            CLS_FETCH: state_nxt = stk_full ? ST_OUT : ST_FETCH;
            CLS_STORE, CLS_PRINT: state_nxt = has1 ? ST_POP : ST_OUT;
            CLS_BIN:   state_nxt = has2 ? ST_RDA : ST_OUT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_POP:    state_nxt = tok_r.cls == CLS_PRINT ? ST_OUT : ST_IDLE;
      ST_FETCH:  state_nxt = ST_IDLE;
      ST_RDA:    state_nxt = ST_RDB;
      ST_RDB:    state_nxt = ST_EXEC;
      ST_EXEC: begin
        if (tok_r.alu == ALU_MUL) begin
          state_nxt = ST_MUL;
        end else if ((tok_r.alu == ALU_DIV || tok_r.alu == ALU_MOD) && a_r != '0) begin
          state_nxt = ST_DIV;
        end else begin
          state_nxt = ST_WB;
        end
      end
      ST_MUL:    if (step_r == 6'd2) state_nxt = ST_WB;
      ST_DIV:    if (step_r == 6'(DIV_STEPS - 1)) state_nxt = ST_FIX;
      ST_FIX:    state_nxt = ST_WB;
      ST_WB:     state_nxt = ST_IDLE;
      ST_OUT:    if (res_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    tok_nxt   = tok_r;
    count_nxt = count_r;
    err_nxt   = err_r;
    vvld_nxt  = vvld_r;
    vsel_nxt  = vsel_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    r_nxt     = r_r;
    rem_nxt   = rem_r;
    step_nxt  = step_r;
    na_nxt    = na_r;
    nb_nxt    = nb_r;
    pend_nxt  = pend_r;
    res_nxt   = res_r;
    s_we      = 1'b0;
    s_waddr   = count_r[AW-1:0];
    s_wdata   = tok_r.val;
    s_raddr   = cm1[AW-1:0];
    v_we      = 1'b0;
    v_wdata   = s_rdata;

    if (res_r.valid && out_ready) res_nxt.valid = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          tok_nxt = q_tok;
          if (q_tok.start) begin
            count_nxt = '0;
            err_nxt   = 1'b0;
            vvld_nxt  = '0;
          end
        end
      end
      ST_DECIDE: begin
        pend_nxt       = '0;
        pend_nxt.valid = 1'b1;
        vsel_nxt       = vin && vvld_r[vaddr];
        if (!err_r) begin
          case (tok_r.cls)
            CLS_CHAR: begin
              pend_nxt.kind  = KIND_CHAR;
              pend_nxt.value = {56'd0, tok_r.val[7:0]};
            end
            CLS_PUSH, CLS_FETCH: begin
              if (stk_full) begin
                pend_nxt.kind = KIND_ERROR;
                pend_nxt.code = ERR_OVERRUN;
                err_nxt       = 1'b1;
              end else if (tok_r.cls == CLS_PUSH) begin
                s_we      = 1'b1;
                count_nxt = count_r + CW'(1);
              end
            end
            CLS_STORE, CLS_PRINT, CLS_BIN: begin
              if (!has1 || (tok_r.cls == CLS_BIN && !has2)) begin
                pend_nxt.kind = KIND_ERROR;
                pend_nxt.code = ERR_UNDERRUN;
                err_nxt       = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        s_we      = 1'b1;
        s_wdata   = vsel_r ? v_rdata : '0;
        count_nxt = count_r + CW'(1);
      end
      ST_POP: begin
        count_nxt = cm1;
        if (tok_r.cls == CLS_STORE && vin) begin
          v_we            = 1'b1;
          vvld_nxt[vaddr] = 1'b1;
        end
        pend_nxt.kind  = KIND_PRINT;
        pend_nxt.pw    = tok_r.pw;
        pend_nxt.value = s_rdata & print_mask(tok_r.pw);
      end
      ST_RDA: begin
        a_nxt   = s_rdata;
        s_raddr = cm2[AW-1:0];
      end
      ST_RDB: b_nxt = s_rdata;
      ST_EXEC: begin
        step_nxt = '0;
        na_nxt   = a_r[DATA_W-1];
        nb_nxt   = b_r[DATA_W-1];
        rem_nxt  = '0;
        case (tok_r.alu)
          ALU_ADD: r_nxt = b_r + a_r;
          ALU_SUB: r_nxt = b_r - a_r;
          ALU_AND: r_nxt = b_r & a_r;
          ALU_OR:  r_nxt = b_r | a_r;
          ALU_XOR: r_nxt = b_r ^ a_r;
          ALU_MIN: r_nxt = $signed(b_r) < $signed(a_r) ? b_r : a_r;
          ALU_MAX: r_nxt = $signed(b_r) < $signed(a_r) ? a_r : b_r;
          ALU_DIV, ALU_MOD: begin
            // magnitudes; quotient shifts in through r
            r_nxt = b_r[DATA_W-1] ? -b_r : b_r;
            a_nxt = a_r[DATA_W-1] ? -a_r : a_r;
            if (a_r == '0) r_nxt = '0;
          end
          default: r_nxt = '0;
        endcase
      end
      ST_MUL: begin
        r_nxt    = step_r == 6'd0 ? prod : r_r + {prod[HALF_W-1:0], 32'd0};
        step_nxt = step_r + 6'd1;
      end
      ST_DIV: begin
        if (!diff[DATA_W]) begin
          rem_nxt = diff[DATA_W-1:0];
          r_nxt   = {r_r[DATA_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh[DATA_W-1:0];
          r_nxt   = {r_r[DATA_W-2:0], 1'b0};
        end
        step_nxt = step_r + 6'd1;
      end
      ST_FIX: begin
        if (tok_r.alu == ALU_MOD) r_nxt = nb_r ? -rem_r : rem_r;
        else                      r_nxt = (nb_r ^ na_r) ? -r_r : r_r;
      end
      ST_WB: begin
        s_we      = 1'b1;
        s_waddr   = cm2[AW-1:0];
        s_wdata   = r_r;
        count_nxt = cm1;
      end
      ST_OUT: if (res_free) res_nxt = pend_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    tok_r  <= tok_nxt;
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    r_r    <= r_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
    na_r   <= na_nxt;
    nb_r   <= nb_nxt;
    vsel_r <= vsel_nxt;
    pend_r <= pend_nxt;
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      err_r   <= 1'b0;
      vvld_r  <= '0;
      res_r   <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      err_r   <= err_nxt;
      vvld_r  <= vvld_nxt;
      res_r   <= res_nxt;
    end
  end
endmodule
